@@ rtl/fmkc_pkg.sv @@
`default_nettype none
package fmkc_pkg;

  localparam int NUM_CHANNELS_DEF = 8;

  localparam logic [7:0] ADDR_FNUM_LO = 8'hA0;
  localparam logic [7:0] ADDR_KEY_BLK = 8'hB0;
  localparam logic [7:0] KEY_BIT      = 8'h20;
  localparam logic [3:0] NOTE_MAX     = 4'd11;
  localparam logic       OP_KEY_ON    = 1'b0;
  localparam logic       OP_KEY_OFF   = 1'b1;

  // microcode addresses
  typedef enum logic [1:0] {
    U_IDLE   = 2'd0,
    U_KON_LO = 2'd1,
    U_KON_HI = 2'd2,
    U_KOFF   = 2'd3
  } uaddr_t;

  typedef struct packed {
    logic   accept;   // step takes an input transfer
    logic   emit;     // step loads the output register
    logic   sel_hi;   // 0xB0 write from stored f-number and block
    logic   key_bit;  // or in the key bit
    logic   last;
    logic   set_key;
    logic   clr_key;
    uaddr_t next;
  } uword_t;

  typedef struct packed {
    logic       set_key;
    logic       clr_key;
    logic [9:0] fnum;
    logic [2:0] blk;
  } chan_wr_t;

  function automatic uword_t urom(input uaddr_t a);
    uword_t w;
    w = '0;
    unique case (a)
      U_IDLE: begin
        w.accept = 1'b1;
        w.next   = U_IDLE;
      end
      U_KON_LO: begin
        w.accept  = 1'b1;
        w.emit    = 1'b1;
        w.set_key = 1'b1;
        w.next    = U_KON_HI;
      end
      U_KON_HI: begin
        w.emit    = 1'b1;
        w.sel_hi  = 1'b1;
        w.key_bit = 1'b1;
        w.last    = 1'b1;
        w.next    = U_IDLE;
      end
      U_KOFF: begin
        w.accept  = 1'b1;
        w.emit    = 1'b1;
        w.sel_hi  = 1'b1;
        w.last    = 1'b1;
        w.clr_key = 1'b1;
        w.next    = U_IDLE;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [9:0] fnum_lookup(input logic [3:0] note, input logic [2:0] oct);
    logic [9:0] f;
    case (note)
      4'd0:    f = (oct == 3'd0) ? 10'd345 : 10'd690;
      4'd1:    f = (oct == 3'd0) ? 10'd365 : 10'd731;
      4'd2:    f = (oct == 3'd0) ? 10'd387 : 10'd774;
      4'd3:    f = (oct == 3'd0) ? 10'd410 : 10'd820;
      4'd4:    f = (oct == 3'd0) ? 10'd435 : 10'd869;
      4'd5:    f = (oct == 3'd0) ? 10'd460 : 10'd921;
      4'd6:    f = (oct == 3'd0) ? 10'd488 : 10'd975;
      4'd7:    f = 10'd517;
      4'd8:    f = 10'd547;
      4'd9:    f = 10'd580;
      4'd10:   f = 10'd615;
      4'd11:   f = 10'd651;
      default: f = 10'd0;
    endcase
    return f;
  endfunction

  function automatic logic [2:0] block_lookup(input logic [3:0] note, input logic [2:0] oct);
    logic [2:0] b;
    if (oct == 3'd0) begin
      b = 3'd0;
    end else if (note < 4'd7) begin
      b = oct - 3'd1;
    end else begin
      b = oct;
    end
    return b;
  endfunction

endpackage
`default_nettype wire

@@ rtl/fm_channel_note_key_controller.sv @@
`default_nettype none
// channel  direction  content
// in_      slave      key on / key off event, one per transfer
// out_     master     register write, address and data, tlast on final write
//
// a key-on for an idle channel loads the 0xA0 write in the accept step
// and the 0xB0 write in the U_KON_HI step after it; a key-off loads its
// 0xB0 write in the accept step. the pace is set by the single output register.
// a stalled out_tready holds the microcode step; in_tready drops with it.
// synchronous reset clears the key flags and the step counter.
module fm_channel_note_key_controller #(
  parameter int NUM_CHANNELS = fmkc_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // chan_index[2:0], note_index[6:3], octave_index[9:7]
  input  wire logic        in_tuser,   // operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // reg_address[7:0], reg_data[15:8]
  output logic             out_tlast
);
  import fmkc_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  uaddr_t            step_r, step_nxt, uaddr;
  uword_t            uw;
  logic [CH_W-1:0]   ch_r, ch_nxt, rd_idx;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [15:0]       out_tdata_r, out_tdata_nxt;
  logic              out_tlast_r, out_tlast_nxt;

  logic       op;
  logic [2:0] chan;
  logic [3:0] note;
  logic [2:0] oct;
  logic       ch_ok, kon_ok, koff_ok, slot_free, fire;
  logic       key_rd, key_act;
  logic [9:0] fnum_rd, fnum_lu;
  logic [2:0] blk_rd, blk_lu;
  logic [7:0] addr, data;
  chan_wr_t   wr;

  assign op   = in_tuser;
  assign chan = in_tdata[2:0];
  assign note = in_tdata[6:3];
  assign oct  = in_tdata[9:7];

  assign ch_ok   = 32'(chan) < 32'(NUM_CHANNELS);
  assign rd_idx  = (step_r == U_IDLE) ? CH_W'(chan) : ch_r;
  assign key_act = ch_ok && key_rd;
  assign kon_ok  = (op == OP_KEY_ON) && ch_ok && !key_act && (note <= NOTE_MAX);
  assign koff_ok = (op == OP_KEY_OFF) && key_act;

  assign fnum_lu = fnum_lookup(note, oct);
  assign blk_lu  = block_lookup(note, oct);

  always_comb begin
    if (step_r != U_IDLE) begin
      uaddr = step_r;
    end else if (in_tvalid && kon_ok) begin
      uaddr = U_KON_LO;
    end else if (in_tvalid && koff_ok) begin
      uaddr = U_KOFF;
    end else begin
      uaddr = U_IDLE;
    end
  end

  assign uw        = urom(uaddr);
  assign slot_free = !out_tvalid_r || out_tready;
  assign fire      = !uw.emit || slot_free;
  assign in_tready = uw.accept && fire;

  assign wr.set_key = uw.set_key && fire;
  assign wr.clr_key = uw.clr_key && fire;
  assign wr.fnum    = fnum_lu;
  assign wr.blk     = blk_lu;

  fmkc_chan_store #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .CH_W        (CH_W)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .idx    (rd_idx),
    .wr     (wr),
    .key_rd (key_rd),
    .fnum_rd(fnum_rd),
    .blk_rd (blk_rd)
  );

  always_comb begin
    addr = (uw.sel_hi ? ADDR_KEY_BLK : ADDR_FNUM_LO) + 8'(rd_idx);
    if (uw.sel_hi) begin
      data = {3'b000, blk_rd, fnum_rd[9:8]} | (uw.key_bit ? KEY_BIT : 8'h00);
    end else begin
      data = fnum_lu[7:0];
    end
  end

  always_comb begin
    step_nxt       = fire ? uw.next : step_r;
    ch_nxt         = rd_idx;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    if (uw.emit && fire) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {data, addr};
      out_tlast_nxt  = uw.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= U_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      step_r       <= step_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    ch_r        <= ch_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule
`default_nettype wire

@@ rtl/fmkc_chan_store.sv @@
`default_nettype none
module fmkc_chan_store #(
  parameter int NUM_CHANNELS = fmkc_pkg::NUM_CHANNELS_DEF,
  parameter int CH_W         = 3
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CH_W-1:0]  idx,
  input  wire fmkc_pkg::chan_wr_t wr,
  output logic                  key_rd,
  output logic [9:0]            fnum_rd,
  output logic [2:0]            blk_rd
);
  import fmkc_pkg::*;

  logic [NUM_CHANNELS-1:0] key_r;
  logic [9:0]              fnum_r [NUM_CHANNELS];
  logic [2:0]              blk_r  [NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (wr.set_key) begin
      key_r[idx] <= 1'b1;
    end else if (wr.clr_key) begin
      key_r[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set_key) begin
      fnum_r[idx] <= wr.fnum;
      blk_r[idx]  <= wr.blk;
    end
  end

  assign key_rd  = key_r[idx];
  assign fnum_rd = fnum_r[idx];
  assign blk_rd  = blk_r[idx];

endmodule
`default_nettype wire

@@ rtl/fmkc_checker.sv @@
`default_nettype none
module fmkc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast
);

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // a write that is not final always goes to the f-number low register
  a_lo_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[7:4] == 4'hA)
    else $error("non-final write not to f-number low register");

  // final write always goes to the key/block register
  a_last_kb: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[7:4] == 4'hB && out_tdata[15:14] == 2'b00)
    else $error("final write malformed");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind fm_channel_note_key_controller fmkc_checker u_fmkc_checker (.*);
`default_nettype wire
